// File: hdl/psg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psg_pkg
// Shared sizes, codes and types of the prefix/suffix GCD exclusion query unit.
// ----------------------------------------------------------------------------
package psg_pkg;

    localparam int MAX_ELEMENTS = 4096;
    localparam int VAL_W        = 31;
    localparam int POS_W        = 13;
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
    localparam int CMP_W        = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam int GCD_K_W      = $clog2(VAL_W);

    typedef enum logic {
        K_LOAD  = 1'b0,
        K_QUERY = 1'b1
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LD_RD,
        S_LD_WAIT,
        S_SB_START,
        S_SB_GCD,
        S_SB_WAIT,
        S_Q_CHK,
        S_Q_RD,
        S_Q_WAIT,
        S_Q_OUT
    } t_state;

    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] a;
        logic [VAL_W-1:0] b;
    } t_gcd_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_gcd_status;

endpackage
`default_nettype wire

// File: hdl/psg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psg_if
// Valid/ready channels: request beats in, result beats out.
// ----------------------------------------------------------------------------
interface psg_req_if;
    import psg_pkg::*;

    logic             valid;
    logic             ready;
    logic             kind;
    logic             first;
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] left;
    logic [POS_W-1:0] right;

    modport source (output valid, kind, first, value, left, right, input ready);
    modport sink   (input valid, kind, first, value, left, right, output ready);
endinterface

interface psg_res_if;
    import psg_pkg::*;

    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] gcd_result;
    logic             bad_range;

    modport source (output valid, gcd_result, bad_range, input ready);
    modport sink   (input valid, gcd_result, bad_range, output ready);
endinterface
`default_nettype wire

// File: hdl/psg_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psg_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module psg_ram #(
    parameter int DATA_W = 31,
    parameter int ADDR_W = 12
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output      logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: hdl/psg_gcd_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psg_gcd_unit
// Iterative binary GCD, one shift or subtract-and-shift step per cycle.
// ----------------------------------------------------------------------------
module psg_gcd_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire psg_pkg::t_gcd_req           i_req,
    output      psg_pkg::t_gcd_status        o_status,
    output      logic [psg_pkg::VAL_W-1:0]   o_result
);
    import psg_pkg::*;

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [VAL_W-1:0]   r_a, n_a;
    logic [VAL_W-1:0]   r_b, n_b;
    logic [GCD_K_W-1:0] r_k, n_k;
    logic [VAL_W-1:0]   r_result, n_result;

    always_comb begin
        n_busy   = r_busy;
        n_done   = 1'b0;
        n_a      = r_a;
        n_b      = r_b;
        n_k      = r_k;
        n_result = r_result;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_a    = i_req.a;
            n_b    = i_req.b;
            n_k    = '0;
        end else if (r_busy) begin
            if (r_a == '0 || r_b == '0) begin
                n_busy   = 1'b0;
                n_done   = 1'b1;
                n_result = (r_a | r_b) << r_k;
            end else if (!r_a[0] && !r_b[0]) begin
                n_a = r_a >> 1;
                n_b = r_b >> 1;
                n_k = r_k + GCD_K_W'(1);
            end else if (!r_a[0]) begin
                n_a = r_a >> 1;
            end else if (!r_b[0]) begin
                n_b = r_b >> 1;
            end else if (r_a >= r_b) begin
                n_a = (r_a - r_b) >> 1;
            end else begin
                n_b = (r_b - r_a) >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a      <= n_a;
        r_b      <= n_b;
        r_k      <= n_k;
        r_result <= n_result;
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_result      = r_result;

endmodule
`default_nettype wire

// File: hdl/prefix_suffix_gcd_exclusion_query_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prefix_suffix_gcd_exclusion_query_unit
// Loads an array with running prefix GCDs, builds suffix GCDs on the first
// query after a load, and answers the GCD of all elements outside a range.
//
//   channel  dir  beat fields
//   i_req    in   kind, first, value, left, right
//   o_res    out  gcd_result, bad_range (one beat per query, none per load)
//
// Load: element write and prefix read, then one data-dependent GCD for the new prefix.
// Query: range check, prefix and suffix reads, one GCD; a bad range skips both.
// The first query after a load first runs a suffix pass, one GCD per element.
// Load, suffix pass and query share one binary GCD unit, one step per cycle.
// Reset clears state, count and flags only; no memory clearing pass.
// A finished result waits in the output register; loads go on meanwhile.
// ----------------------------------------------------------------------------
module prefix_suffix_gcd_exclusion_query_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    psg_req_if.sink    i_req,
    psg_res_if.source  o_res
);
    import psg_pkg::*;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_sfx_ready, n_sfx_ready;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic [VAL_W-1:0]   r_acc, n_acc;
    logic [VAL_W-1:0]   r_elem, n_elem;
    logic [VAL_W-1:0]   r_val, n_val;
    logic [CNT_W-1:0]   r_widx, n_widx;
    logic [POS_W-1:0]   r_left, n_left;
    logic [POS_W-1:0]   r_right, n_right;
    logic               r_p_zero, n_p_zero;
    logic               r_s_zero, n_s_zero;
    logic [VAL_W-1:0]   r_res, n_res;
    logic               r_bad, n_bad;
    logic               r_out_valid, n_out_valid;
    logic [VAL_W-1:0]   r_out_gcd, n_out_gcd;
    logic               r_out_bad, n_out_bad;

    logic               in_ready;
    logic [CNT_W-1:0]   cnt_eff;
    logic [CMP_W-1:0]   q_l, q_r, q_c;
    logic               q_bad;

    t_gcd_req           gcd_req;
    t_gcd_status        gcd_st;
    logic [VAL_W-1:0]   gcd_res;

    // element / suffix memory, word = {element, suffix}, address = position - 1
    logic                ew_en, er_en;
    logic [ADDR_W-1:0]   ew_addr, er_addr;
    logic [2*VAL_W-1:0]  ew_data, er_data;
    // prefix memory, address = position - 1 (position zero reads as 0)
    logic                pw_en, pr_en;
    logic [ADDR_W-1:0]   pw_addr, pr_addr;
    logic [VAL_W-1:0]    pw_data, pr_data;

    psg_ram #(.DATA_W(2 * VAL_W), .ADDR_W(ADDR_W)) u_elem_ram (
        .i_clk   (i_clk),
        .i_we    (ew_en),
        .i_waddr (ew_addr),
        .i_wdata (ew_data),
        .i_re    (er_en),
        .i_raddr (er_addr),
        .o_rdata (er_data)
    );

    psg_ram #(.DATA_W(VAL_W), .ADDR_W(ADDR_W)) u_prefix_ram (
        .i_clk   (i_clk),
        .i_we    (pw_en),
        .i_waddr (pw_addr),
        .i_wdata (pw_data),
        .i_re    (pr_en),
        .i_raddr (pr_addr),
        .o_rdata (pr_data)
    );

    psg_gcd_unit u_gcd (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (gcd_req),
        .o_status (gcd_st),
        .o_result (gcd_res)
    );

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_sfx_ready = r_sfx_ready;
        n_idx       = r_idx;
        n_acc       = r_acc;
        n_elem      = r_elem;
        n_val       = r_val;
        n_widx      = r_widx;
        n_left      = r_left;
        n_right     = r_right;
        n_p_zero    = r_p_zero;
        n_s_zero    = r_s_zero;
        n_res       = r_res;
        n_bad       = r_bad;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_gcd   = r_out_gcd;
        n_out_bad   = r_out_bad;
        in_ready    = 1'b0;
        gcd_req     = '0;
        ew_en       = 1'b0;
        ew_addr     = '0;
        ew_data     = '0;
        er_en       = 1'b0;
        er_addr     = '0;
        pw_en       = 1'b0;
        pw_addr     = '0;
        pw_data     = '0;
        pr_en       = 1'b0;
        pr_addr     = '0;
        cnt_eff     = i_req.first ? '0 : r_cnt;
        q_l         = CMP_W'(r_left);
        q_r         = CMP_W'(r_right);
        q_c         = CMP_W'(r_cnt);
        q_bad       = (q_l == '0) || (q_r > q_c) || (q_l > q_r);

        case (r_state)
            S_IDLE: begin
                in_ready = 1'b1;
                if (i_req.valid) begin
                    if (i_req.kind == K_LOAD) begin
                        if (cnt_eff < CNT_W'(MAX_ELEMENTS)) begin
                            ew_en    = 1'b1;
                            ew_addr  = ADDR_W'(cnt_eff);
                            ew_data  = {i_req.value, VAL_W'(0)};
                            pr_en    = (cnt_eff != '0);
                            pr_addr  = ADDR_W'(cnt_eff - CNT_W'(1));
                            n_p_zero = (cnt_eff == '0);
                            n_widx   = cnt_eff;
                            n_val    = i_req.value;
                            n_state  = S_LD_RD;
                        end
                    end else begin
                        n_left  = i_req.left;
                        n_right = i_req.right;
                        n_idx   = r_cnt;
                        n_acc   = '0;
                        n_state = r_sfx_ready ? S_Q_CHK : S_SB_START;
                    end
                end
            end
            S_LD_RD: begin
                gcd_req.start = 1'b1;
                gcd_req.a     = r_p_zero ? '0 : pr_data;
                gcd_req.b     = r_val;
                n_state       = S_LD_WAIT;
            end
            S_LD_WAIT: begin
                if (gcd_st.done) begin
                    pw_en       = 1'b1;
                    pw_addr     = ADDR_W'(r_widx);
                    pw_data     = gcd_res;
                    n_cnt       = r_widx + CNT_W'(1);
                    n_sfx_ready = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            S_SB_START: begin
                if (r_idx == '0) begin
                    n_sfx_ready = 1'b1;
                    n_state     = S_Q_CHK;
                end else begin
                    er_en   = 1'b1;
                    er_addr = ADDR_W'(r_idx - CNT_W'(1));
                    n_state = S_SB_GCD;
                end
            end
            S_SB_GCD: begin
                n_elem        = er_data[2*VAL_W-1:VAL_W];
                gcd_req.start = 1'b1;
                gcd_req.a     = r_acc;
                gcd_req.b     = er_data[2*VAL_W-1:VAL_W];
                n_state       = S_SB_WAIT;
            end
            S_SB_WAIT: begin
                if (gcd_st.done) begin
                    ew_en   = 1'b1;
                    ew_addr = ADDR_W'(r_idx - CNT_W'(1));
                    ew_data = {r_elem, gcd_res};
                    n_acc   = gcd_res;
                    n_idx   = r_idx - CNT_W'(1);
                    n_state = S_SB_START;
                end
            end
            S_Q_CHK: begin
                if (q_bad) begin
                    n_res   = '0;
                    n_bad   = 1'b1;
                    n_state = S_Q_OUT;
                end else begin
                    n_p_zero = (q_l == CMP_W'(1));
                    n_s_zero = (q_r == q_c);
                    pr_en    = (q_l != CMP_W'(1));
                    pr_addr  = ADDR_W'(r_left - POS_W'(2));
                    er_en    = (q_r != q_c);
                    er_addr  = ADDR_W'(r_right);
                    n_state  = S_Q_RD;
                end
            end
            S_Q_RD: begin
                gcd_req.start = 1'b1;
                gcd_req.a     = r_p_zero ? '0 : pr_data;
                gcd_req.b     = r_s_zero ? '0 : er_data[VAL_W-1:0];
                n_state       = S_Q_WAIT;
            end
            S_Q_WAIT: begin
                if (gcd_st.done) begin
                    n_res   = gcd_res;
                    n_bad   = 1'b0;
                    n_state = S_Q_OUT;
                end
            end
            S_Q_OUT: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out_gcd   = r_res;
                    n_out_bad   = r_bad;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_sfx_ready <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_sfx_ready <= n_sfx_ready;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_acc     <= n_acc;
        r_elem    <= n_elem;
        r_val     <= n_val;
        r_widx    <= n_widx;
        r_left    <= n_left;
        r_right   <= n_right;
        r_p_zero  <= n_p_zero;
        r_s_zero  <= n_s_zero;
        r_res     <= n_res;
        r_bad     <= n_bad;
        r_out_gcd <= n_out_gcd;
        r_out_bad <= n_out_bad;
    end

    assign i_req.ready      = in_ready;
    assign o_res.valid      = r_out_valid;
    assign o_res.gcd_result = r_out_gcd;
    assign o_res.bad_range  = r_out_bad;

    a_gcd_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        gcd_req.start |-> !gcd_st.busy)
        else $error("GCD started while busy");

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_ELEMENTS))
        else $error("element count above capacity");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.bad_range) |-> (o_res.gcd_result == '0))
        else $error("bad range beat with nonzero result");

    a_sfx_after_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sfx_ready) |-> ($past(r_state) == S_SB_START))
        else $error("suffix marked ready outside suffix pass");

endmodule
`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives load and query beats into the prefix/suffix GCD exclusion query unit.
// The sequence is a directed opening, then mostly well-formed random arrays
// with queries, and last one long array. Random gaps and stalls fall on both
// channels. A scoreboard keeps its own copy of the array with prefix and suffix
// GCDs and compares every result beat with the oldest expected answer.
// ----------------------------------------------------------------------------
module testbench;
    import psg_pkg::*;

    localparam int RANDOM_ITEMS = 1700;
    localparam int LONG_ITEMS   = 200;
    localparam int HOLD_CYCLES  = 3000;
    localparam int HOLD_AT      = 40;
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 30_000_000;

    typedef struct packed {
        logic [VAL_W-1:0] gcd;
        logic             bad;
    } t_answer;

    class exclusion_gcd_board;
        bit [VAL_W-1:0] elems  [MAX_ELEMENTS];
        bit [VAL_W-1:0] prefix [MAX_ELEMENTS+1];
        bit [VAL_W-1:0] suffix [MAX_ELEMENTS+2];
        int             count;
        bit             suffix_fresh;
        t_answer        expected_answers[$];
        int             loads, dropped, queries, out_of_range, checked, mismatches;

        function new();
            prefix[0] = '0;
        endfunction

        function bit [VAL_W-1:0] gcd_of(bit [VAL_W-1:0] x, bit [VAL_W-1:0] y);
            bit [VAL_W-1:0] r;
            while (y != 0) begin
                r = x % y;
                x = y;
                y = r;
            end
            return x;
        endfunction

        function void note_request(t_kind kind, bit first, bit [VAL_W-1:0] value,
                                   int left, int right);
            t_answer ans;
            int      i;
            if (kind == K_LOAD) begin
                loads++;
                if (first)
                    count = 0;
                if (count >= MAX_ELEMENTS) begin
                    dropped++;
                    return;
                end
                elems[count]      = value;
                prefix[count + 1] = gcd_of(prefix[count], value);
                count++;
                suffix_fresh = 1'b0;
                return;
            end
            queries++;
            if (!suffix_fresh) begin
                suffix[count + 1] = '0;
                for (i = count; i >= 1; i--)
                    suffix[i] = gcd_of(suffix[i + 1], elems[i - 1]);
                suffix_fresh = 1'b1;
            end
            if (left < 1 || right > count || left > right) begin
                out_of_range++;
                ans.gcd = '0;
                ans.bad = 1'b1;
            end else begin
                ans.gcd = gcd_of(prefix[left - 1], suffix[right + 1]);
                ans.bad = 1'b0;
            end
            expected_answers.push_back(ans);
        endfunction

        task flag(string msg);
            mismatches++;
            if (mismatches <= 20)
                $display("MISMATCH @%0t: %s", $realtime, msg);
        endtask

        task check_result(logic [VAL_W-1:0] gcd, logic bad);
            t_answer ans;
            checked++;
            if (expected_answers.size() == 0) begin
                flag($sformatf("unexpected result beat gcd=%0d bad=%0b", gcd, bad));
                return;
            end
            ans = expected_answers.pop_front();
            if (gcd !== ans.gcd)
                flag($sformatf("result %0d: gcd %0d, expected %0d", checked, gcd, ans.gcd));
            if (bad !== ans.bad)
                flag($sformatf("result %0d: bad_range %0b, expected %0b", checked, bad,
                               ans.bad));
        endtask

        function int pending();
            return expected_answers.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    psg_req_if req_ch ();
    psg_res_if res_ch ();

    prefix_suffix_gcd_exclusion_query_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    exclusion_gcd_board sb = new();
    int items_sent;
    bit send_calm;
    bit recv_calm;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int pick_gap(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // called at a falling edge, returns at a falling edge after the beat and any random gap
    task automatic send_item(t_kind kind, logic first, logic [VAL_W-1:0] value,
                             int left, int right);
        int gap;
        req_ch.valid <= 1'b1;
        req_ch.kind  <= kind;
        req_ch.first <= first;
        req_ch.value <= value;
        req_ch.left  <= left[POS_W-1:0];
        req_ch.right <= right[POS_W-1:0];
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        items_sent++;
        @(negedge i_clk);
        gap = pick_gap(send_calm);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic send_load(logic first, logic [VAL_W-1:0] value);
        send_item(K_LOAD, first, value, $urandom_range(0, 4096), $urandom_range(0, 4096));
    endtask

    task automatic send_query(int left, int right);
        send_item(K_QUERY, 1'($urandom()), VAL_W'($urandom()), left, right);
    endtask

    function automatic logic [VAL_W-1:0] make_value(int style, int base);
        int r;
        r = $urandom_range(0, 7);
        case (style)
            0: return VAL_W'($urandom());
            1: return VAL_W'(base * $urandom_range(1, 9));
            2: return (r < 2) ? '0 : VAL_W'(base * $urandom_range(1, 30));
            default: begin
                case (r)
                    0, 1: return '0;
                    2:    return VAL_W'(1);
                    3:    return {VAL_W{1'b1}};
                    4:    return VAL_W'(1) << $urandom_range(0, VAL_W - 1);
                    default: return VAL_W'($urandom());
                endcase
            end
        endcase
    endfunction

    task automatic random_query();
        int c, l, r;
        c = sb.count;
        if (c == 0) begin
            send_query($urandom_range(0, 4096), $urandom_range(0, 4096));
            return;
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                l = $urandom_range(1, c);
                r = $urandom_range(l, c);
            end
            5: begin
                l = $urandom_range(1, c);
                r = c;
            end
            6: begin
                l = 1;
                r = $urandom_range(1, c);
            end
            7: begin
                r = $urandom_range(0, c);
                l = r + 1;
            end
            8: begin
                l = $urandom_range(0, 1);
                r = $urandom_range(c, c + 1);
            end
            default: begin
                l = $urandom_range(0, 4096);
                r = $urandom_range(0, 4096);
            end
        endcase
        send_query(l, r);
    endtask

    task automatic random_array();
        int n, style, base, rounds, k;
        n      = ($urandom_range(0, 19) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
        style  = $urandom_range(0, 3);
        base   = $urandom_range(1, 65535);
        rounds = ($urandom_range(0, 2) == 0) ? 2 : 1;
        for (k = 0; k < n; k++)
            send_load(k == 0, make_value(style, base));
        for (k = 0; k < rounds; k++) begin
            if (k > 0)
                repeat ($urandom_range(1, 3)) send_load(1'b0, make_value(style, base));
            repeat ($urandom_range(1, 8)) random_query();
        end
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 1) == 0)
                send_item(K_LOAD, ($urandom_range(0, 3) == 0), VAL_W'($urandom()),
                          $urandom_range(0, 4096), $urandom_range(0, 4096));
            else
                random_query();
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
                sb.check_result(res_ch.gcd_result, res_ch.bad_range);
            if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
                sb.note_request(t_kind'(req_ch.kind), req_ch.first, req_ch.value,
                                int'(req_ch.left), int'(req_ch.right));
        end
    end

    // result side: random back-pressure plus one long hold-off
    initial begin : receiver
        int gap, taken;
        taken        = 0;
        res_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (res_ch.valid !== 1'b1);
            taken++;
            @(negedge i_clk);
            if (taken % 64 == 0)
                recv_calm = ($urandom_range(0, 3) == 0);
            if (taken == HOLD_AT) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                gap = pick_gap(recv_calm);
                if (gap > 0) begin
                    res_ch.ready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
        $display("[prefix_suffix_gcd_exclusion_query_unit] ERROR");
        $finish;
    end

    initial begin : stimulus
        int k;
        i_rst_n      = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.kind  = K_LOAD;
        req_ch.first = 1'b0;
        req_ch.value = '0;
        req_ch.left  = '0;
        req_ch.right = '0;
        items_sent   = 0;
        send_calm    = 1'b0;
        recv_calm    = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty array, extreme values, zeros, full exclusion, bad ranges
        send_query(1, 1);
        send_query(0, 0);
        send_load(1'b1, {VAL_W{1'b1}});
        send_load(1'b0, '0);
        send_load(1'b0, {{(VAL_W-1){1'b1}}, 1'b0});
        send_load(1'b0, VAL_W'(12));
        send_query(1, 1);
        send_query(1, 4);
        send_query(2, 3);
        send_query(4, 4);
        send_query(0, 2);
        send_query(3, 5);
        send_query(3, 2);
        send_query(4096, 4096);
        send_query(1, 4096);
        send_load(1'b1, '0);
        send_query(1, 1);
        send_load(1'b0, '0);
        send_query(2, 2);
        send_load(1'b1, VAL_W'(1));
        send_load(1'b0, VAL_W'(1) << (VAL_W - 1));
        send_query(2, 2);
        send_query(1, 1);

        k = items_sent + RANDOM_ITEMS;
        while (items_sent < k) begin
            send_calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 99) < 80)
                random_array();
            else
                noise_burst();
        end
        send_calm = 1'b0;

        // long array, queries across both ends
        send_load(1'b1, VAL_W'(6 * $urandom_range(1, 40)));
        repeat (LONG_ITEMS - 1) send_load(1'b0, VAL_W'(6 * $urandom_range(0, 40)));
        send_load(1'b0, {VAL_W{1'b1}});
        send_load(1'b0, VAL_W'(1));
        send_query(1, LONG_ITEMS + 2);
        send_query(LONG_ITEMS, LONG_ITEMS);
        send_query(2, LONG_ITEMS - 1);
        send_query(1, 1);
        send_query(0, LONG_ITEMS);
        send_query(100, 150);
        send_load(1'b1, VAL_W'(42));
        send_query(1, 1);
        send_query(1, 2);
        req_ch.valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.pending() != 0)
            sb.flag($sformatf("%0d expected results never arrived", sb.pending()));
        $display("run: %0d loads (%0d dropped on a full array), %0d queries (%0d bad ranges)",
                 sb.loads, sb.dropped, sb.queries, sb.out_of_range);
        $display("run: %0d result beats checked, %0d mismatches", sb.checked, sb.mismatches);
        if (sb.mismatches == 0)
            $display("[prefix_suffix_gcd_exclusion_query_unit] OK");
        else
            $display("[prefix_suffix_gcd_exclusion_query_unit] ERROR");
        $finish;
    end

endmodule

// File: sim.f
hdl/psg_pkg.sv
hdl/psg_if.sv
hdl/psg_ram.sv
hdl/psg_gcd_unit.sv
hdl/prefix_suffix_gcd_exclusion_query_unit.sv
bench/testbench.sv
